// ===== hdl/keyed_counter_random_hash_top_macros.svh =====
// Assertion macros shared by the checker of keyed_counter_random_hash_top.
// No dependencies; included by files that carry assertions.
`ifndef KEYED_COUNTER_RANDOM_HASH_TOP_MACROS_SVH
`define KEYED_COUNTER_RANDOM_HASH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KRH_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define KRH_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== hdl/krh_pkg.sv =====
// Package for the keyed counter-based random hash: mixing constants,
// key offsets, pipeline latency and the folded 64-bit product helper. No dependencies.
package krh_pkg;

    localparam logic [63:0] MIX_GAMMA   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam logic [63:0] OFS_ITER    = 64'h243f6a8885a308d3;
    localparam logic [63:0] OFS_ENTITY  = 64'h13198a2e03707344;
    localparam logic [63:0] OFS_PURPOSE = 64'ha4093822299f31d0;
    localparam logic [63:0] OFS_SAMPLE  = 64'h082efa98ec4e6c89;
    localparam logic [63:0] OFS_NONE    = 64'h0;

    // Register stages in one finalizer lane
    localparam int unsigned FIN_STAGES = 5;
    // Key lanes, then the final mix
    localparam int unsigned LATENCY    = 2 * FIN_STAGES;

    // Low 64 bits of a 64x64 product from its 32x32 partial products
    function automatic logic [63:0] mul_fold(input logic [63:0] ll,
                                             input logic [31:0] lh,
                                             input logic [31:0] hl);
        logic [31:0] mid_sum;
        mid_sum  = lh + hl;
        mul_fold = ll + {mid_sum, 32'h0};
    endfunction

endpackage

// ===== hdl/keyed_counter_random_hash_top.sv =====
// Top level of the keyed counter-based random hash (splitmix64 style).
// Depends on krh_pkg and krh_finalizer.
//
//  channel   signals                                        direction
//  input     in_valid/in_stall, iteration, entity_id,        in
//            purpose, sample_number
//  output    out_valid/out_stall, random_word                out
//  config    cfg_we, cfg_wdata (seed)                        in
//
// One item per cycle while the output is not stalled; each result passes through
// two finalizer lanes of five stages each (32x32 partial products, then fold).
// Reset clears the seed to zero and empties the pipeline.
// When a result waits at the output under stall, the whole pipeline holds
// and in_stall rises; nothing is lost or repeated.
module keyed_counter_random_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] iteration,
    input  logic [63:0] entity_id,
    input  logic [7:0]  purpose,
    input  logic [63:0] sample_number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] random_word
);
    import krh_pkg::*;

    logic [63:0]         seed_reg;
    logic [LATENCY-1:0]  vld_reg, vld_next;
    logic                en;
    logic [63:0]         f_seed, f_iter, f_ent, f_purp, f_samp;
    logic [63:0]         key;

    // Pipeline advances unless a finished item is held at the output
    assign en       = !(vld_reg[LATENCY-1] && out_stall);
    assign in_stall = !en;

    // Seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= 64'h0;
        else if (cfg_we)
            seed_reg <= cfg_wdata;
    end

    // Valid bits travel with the data
    assign vld_next = {vld_reg[LATENCY-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // Key lanes
    krh_finalizer u_fin_seed (.clk(clk), .en(en), .x_in(seed_reg), .ofs(OFS_NONE),
                              .y_out(f_seed));
    krh_finalizer u_fin_iter (.clk(clk), .en(en), .x_in(iteration), .ofs(OFS_ITER),
                              .y_out(f_iter));
    krh_finalizer u_fin_ent  (.clk(clk), .en(en), .x_in(entity_id), .ofs(OFS_ENTITY),
                              .y_out(f_ent));
    krh_finalizer u_fin_purp (.clk(clk), .en(en), .x_in({56'h0, purpose}),
                              .ofs(OFS_PURPOSE), .y_out(f_purp));
    krh_finalizer u_fin_samp (.clk(clk), .en(en), .x_in(sample_number), .ofs(OFS_SAMPLE),
                              .y_out(f_samp));

    // Combine key parts and mix once more
    assign key = f_seed ^ f_iter ^ f_ent ^ f_purp ^ f_samp;

    krh_finalizer u_fin_key  (.clk(clk), .en(en), .x_in(key), .ofs(OFS_NONE),
                              .y_out(random_word));

    assign out_valid = vld_reg[LATENCY-1];

endmodule

// ===== hdl/krh_finalizer.sv =====
// One splitmix64 finalizer lane, five register stages, advancing on en.
// Depends on krh_pkg.
module krh_finalizer (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] x_in,
    input  logic [63:0] ofs,
    output logic [63:0] y_out
);
    import krh_pkg::*;

    logic [63:0] s1_reg, s1_next;
    logic [63:0] ll_a_reg, ll_a_next;
    logic [31:0] lh_a_reg, lh_a_next, hl_a_reg, hl_a_next;
    logic [63:0] s3_reg, s3_next;
    logic [63:0] ll_b_reg, ll_b_next;
    logic [31:0] lh_b_reg, lh_b_next, hl_b_reg, hl_b_next;
    logic [63:0] s5_reg, s5_next;
    logic [63:0] sum0, sum_a, sum_b;

    // Stage 1: offset plus gamma, first xor-shift
    always_comb
    begin
        sum0    = x_in + ofs + MIX_GAMMA;
        s1_next = sum0 ^ (sum0 >> 30);
    end

    // Stage 2: partial products by the first multiplier
    always_comb
    begin
        ll_a_next = 64'(s1_reg[31:0]) * 64'(MIX_MUL_A[31:0]);
        lh_a_next = 32'(s1_reg[31:0] * MIX_MUL_A[63:32]);
        hl_a_next = 32'(s1_reg[63:32] * MIX_MUL_A[31:0]);
    end

    // Stage 3: fold product, second xor-shift
    always_comb
    begin
        sum_a   = mul_fold(ll_a_reg, lh_a_reg, hl_a_reg);
        s3_next = sum_a ^ (sum_a >> 27);
    end

    // Stage 4: partial products by the second multiplier
    always_comb
    begin
        ll_b_next = 64'(s3_reg[31:0]) * 64'(MIX_MUL_B[31:0]);
        lh_b_next = 32'(s3_reg[31:0] * MIX_MUL_B[63:32]);
        hl_b_next = 32'(s3_reg[63:32] * MIX_MUL_B[31:0]);
    end

    // Stage 5: fold product, last xor-shift
    always_comb
    begin
        sum_b   = mul_fold(ll_b_reg, lh_b_reg, hl_b_reg);
        s5_next = sum_b ^ (sum_b >> 31);
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            ll_a_reg <= ll_a_next;
            lh_a_reg <= lh_a_next;
            hl_a_reg <= hl_a_next;
            s3_reg   <= s3_next;
            ll_b_reg <= ll_b_next;
            lh_b_reg <= lh_b_next;
            hl_b_reg <= hl_b_next;
            s5_reg   <= s5_next;
        end
    end

    assign y_out = s5_reg;

endmodule

// ===== hdl/krh_checker.sv =====
// Port-level checker for keyed_counter_random_hash_top, with its bind.
// Depends on keyed_counter_random_hash_top_macros.svh.
`include "keyed_counter_random_hash_top_macros.svh"

module krh_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] random_word
);
    // A stalled result stays offered
    `KRH_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // A stalled result keeps its value
    `KRH_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(random_word))

    // Input backpressure only while a result waits at the output
    `KRH_ASSERT_IMP(a_in_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // With the output free, the input is never stalled
    `KRH_ASSERT_IMP(a_in_free, clk, rst_n, !out_valid || !out_stall, !in_stall)

endmodule

bind keyed_counter_random_hash_top krh_checker u_krh_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .random_word(random_word)
);
